// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port checker of the query block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RFPQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfpq: implication violated");

// Next-cycle implication, disabled while reset is high.
`define RFPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfpq: next-cycle implication violated");

// Next-cycle implication that is also checked across reset.
`define RFPQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rfpq: property violated around reset");

`endif

// ----- rtl/core/rfpq_pkg.sv -----
// Shared types and constants of the range frequency-power query block.
// Used by the top level and the port checker; depends on nothing.
package rfpq_pkg;

   localparam int INDEX_W  = 10;
   localparam int ELEM_W   = 7;
   localparam int ANSWER_W = 27;

   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_QUERY     = 1'b1;
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [INDEX_W-1:0] element_index;
      logic [ELEM_W-1:0]  element_value;
      logic [INDEX_W-1:0] query_left;
      logic [INDEX_W-1:0] query_right;
   } req_type;

   typedef struct packed {
      logic [ANSWER_W-1:0] answer;
      logic                status;
   } rsp_type;

endpackage

// ----- rtl/core/rfpq_ram.sv -----
// Simple dual-port synchronous memory: one write and one read port, read data registered.
// Depends on nothing; used for the element store and the value count table.
module rfpq_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 7,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/range_frequency_power_query.sv -----
// Range frequency-power query block: top level with the window sequencer.
// Depends on rfpq_pkg and rfpq_ram (element store and value count table).
//
// An in-range write beat stores one element and empties the window; the count table is then
// cleared one entry a cycle, and the next beat is taken only once that clear is done. After
// reset both memories are cleared in one pass over the larger of the two, during which
// req_stall stays high. A query moves the two window edges one element at a time until they
// reach the queried range; each move reads the element store, then the count table, then
// writes the count back. A query with left above right goes straight to the reply without
// moving the window. A new beat is taken while a finished answer still waits on rsp_stall;
// only the next answer waits for the output register.
module range_frequency_power_query #(
   parameter int ARRAY_DEPTH = 1024,
   parameter int VALUE_COUNT = 128
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rfpq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rfpq_pkg::rsp_type rsp_data
);
   import rfpq_pkg::*;

   localparam int AW        = $clog2(ARRAY_DEPTH);
   localparam int VW        = $clog2(VALUE_COUNT);
   localparam int CNT_W     = $clog2(ARRAY_DEPTH + 1);
   localparam int CLR_DEPTH = (ARRAY_DEPTH > VALUE_COUNT) ? ARRAY_DEPTH : VALUE_COUNT;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int MUL_W     = CNT_W + 1 + ELEM_W;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_SEEK   = 6'b000100,
      ST_FETCH  = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_REPLY  = 6'b100000
   } state_type;

   typedef enum logic {
      OP_TAKE = 1'b0,
      OP_DROP = 1'b1
   } op_type;

   state_type           state_ff, state_in;
   logic [CLR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                clr_elem_ff, clr_elem_in;
   logic [AW-1:0]       start_ff, start_in;
   logic [AW:0]         endx_ff, endx_in;
   logic [AW-1:0]       left_ff, left_in;
   logic [AW:0]         end_ff, end_in;
   logic [ANSWER_W-1:0] sum_ff, sum_in;
   logic [ANSWER_W-1:0] prod_ff, prod_in;
   logic                pend_ff, pend_in;
   op_type              op_ff, op_in;
   logic [ELEM_W-1:0]   val_ff, val_in;
   logic                rej_ff, rej_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic              elem_wr_en, elem_rd_en;
   logic [AW-1:0]     elem_wr_addr, elem_rd_addr;
   logic [ELEM_W-1:0] elem_wr_data, elem_rd_data;
   logic              cnt_wr_en, cnt_rd_en;
   logic [VW-1:0]     cnt_wr_addr, cnt_rd_addr;
   logic [CNT_W-1:0]  cnt_wr_data, cnt_rd_data;

   logic [ELEM_W-1:0] val_sat;
   logic [AW-1:0]     left_sat, right_sat;
   logic [CLR_W-1:0]  clr_last;
   logic [AW:0]       endx_dec;
   logic [CNT_W-1:0]  cnt_new;
   logic [CNT_W:0]    odd;
   logic [MUL_W-1:0]  mul;

   rfpq_ram #(.DEPTH(ARRAY_DEPTH), .WIDTH(ELEM_W)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_wr_en),
      .wr_addr (elem_wr_addr),
      .wr_data (elem_wr_data),
      .rd_en   (elem_rd_en),
      .rd_addr (elem_rd_addr),
      .rd_data (elem_rd_data)
   );

   rfpq_ram #(.DEPTH(VALUE_COUNT), .WIDTH(CNT_W)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (cnt_rd_en),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   // Saturation of the beat fields; the left > right test uses the raw fields.
   always_comb begin
      val_sat = (32'(req_data.element_value) >= VALUE_COUNT) ?
                ELEM_W'(VALUE_COUNT - 1) : req_data.element_value;
      left_sat = (32'(req_data.query_left) > ARRAY_DEPTH - 1) ?
                 AW'(ARRAY_DEPTH - 1) : AW'(req_data.query_left);
      right_sat = (32'(req_data.query_right) > ARRAY_DEPTH - 1) ?
                  AW'(ARRAY_DEPTH - 1) : AW'(req_data.query_right);
      clr_last = clr_elem_ff ? CLR_W'(CLR_DEPTH - 1) : CLR_W'(VALUE_COUNT - 1);
      endx_dec = endx_ff - 1'b1;
   end

   // Count update: adding one copy of v raises the sum by (2c+1)v, removing one lowers it
   // by (2c-1)v. A removal from an empty count leaves everything as it is.
   always_comb begin
      if (op_ff == OP_TAKE) begin
         cnt_new = cnt_rd_data + 1'b1;
         odd     = {cnt_rd_data, 1'b1};
      end else if (cnt_rd_data == '0) begin
         cnt_new = cnt_rd_data;
         odd     = '0;
      end else begin
         cnt_new = cnt_rd_data - 1'b1;
         odd     = {cnt_rd_data, 1'b0} - 1'b1;
      end
      mul = MUL_W'(odd) * MUL_W'(val_ff);
   end

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      clr_elem_in  = clr_elem_ff;
      start_in     = start_ff;
      endx_in      = endx_ff;
      left_in      = left_ff;
      end_in       = end_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      pend_in      = pend_ff;
      op_in        = op_ff;
      val_in       = val_ff;
      rej_in       = rej_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      elem_wr_en   = 1'b0;
      elem_wr_addr = AW'(req_data.element_index);
      elem_wr_data = val_sat;
      elem_rd_en   = 1'b0;
      elem_rd_addr = start_ff;
      cnt_wr_en    = 1'b0;
      cnt_wr_addr  = VW'(val_ff);
      cnt_wr_data  = cnt_new;
      cnt_rd_en    = 1'b0;
      cnt_rd_addr  = VW'(elem_rd_data);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            if (32'(clr_cnt_ff) < VALUE_COUNT) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_addr = clr_cnt_ff[VW-1:0];
               cnt_wr_data = '0;
            end
            if (clr_elem_ff && 32'(clr_cnt_ff) < ARRAY_DEPTH) begin
               elem_wr_en   = 1'b1;
               elem_wr_addr = clr_cnt_ff[AW-1:0];
               elem_wr_data = '0;
            end
            if (clr_cnt_ff == clr_last) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == CMD_WRITE) begin
                  // A write beyond the array is dropped and keeps the window.
                  if (32'(req_data.element_index) < ARRAY_DEPTH) begin
                     elem_wr_en  = 1'b1;
                     start_in    = '0;
                     endx_in     = '0;
                     sum_in      = '0;
                     clr_elem_in = 1'b0;
                     clr_cnt_in  = '0;
                     state_in    = ST_CLEAR;
                  end
               end else if (req_data.query_left > req_data.query_right) begin
                  rej_in   = 1'b1;
                  state_in = ST_REPLY;
               end else begin
                  rej_in   = 1'b0;
                  left_in  = left_sat;
                  end_in   = {1'b0, right_sat} + 1'b1;
                  // An empty window restarts at the left edge of the query.
                  if ({1'b0, start_ff} == endx_ff) begin
                     start_in = left_sat;
                     endx_in  = {1'b0, left_sat};
                  end
                  state_in = ST_SEEK;
               end
            end
         end
         ST_SEEK: begin
            if (pend_ff) begin
               sum_in  = (op_ff == OP_TAKE) ? sum_ff + prod_ff : sum_ff - prod_ff;
               pend_in = 1'b0;
            end
            // Widen first (left edge down, right edge up), then narrow.
            if (start_ff > left_ff) begin
               elem_rd_en   = 1'b1;
               elem_rd_addr = start_ff - 1'b1;
               start_in     = start_ff - 1'b1;
               op_in        = OP_TAKE;
               state_in     = ST_FETCH;
            end else if (endx_ff < end_ff) begin
               elem_rd_en   = 1'b1;
               elem_rd_addr = endx_ff[AW-1:0];
               endx_in      = endx_ff + 1'b1;
               op_in        = OP_TAKE;
               state_in     = ST_FETCH;
            end else if (endx_ff > end_ff) begin
               elem_rd_en   = 1'b1;
               elem_rd_addr = endx_dec[AW-1:0];
               endx_in      = endx_dec;
               op_in        = OP_DROP;
               state_in     = ST_FETCH;
            end else if (start_ff < left_ff) begin
               elem_rd_en   = 1'b1;
               elem_rd_addr = start_ff;
               start_in     = start_ff + 1'b1;
               op_in        = OP_DROP;
               state_in     = ST_FETCH;
            end else begin
               state_in = ST_REPLY;
            end
         end
         ST_FETCH: begin
            cnt_rd_en = 1'b1;
            val_in    = elem_rd_data;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // The next count read comes in ST_FETCH after ST_SEEK, so it sees this write.
            cnt_wr_en = 1'b1;
            prod_in   = ANSWER_W'(mul);
            pend_in   = 1'b1;
            state_in  = ST_SEEK;
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in.answer = rej_ff ? '0 : sum_ff;
               rsp_data_in.status = rej_ff ? STATUS_REJECT : STATUS_OK;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         clr_elem_ff  <= 1'b1;
         start_ff     <= '0;
         endx_ff      <= '0;
         sum_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_elem_ff  <= clr_elem_in;
         start_ff     <= start_in;
         endx_ff      <= endx_in;
         sum_ff       <= sum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      end_ff      <= end_in;
      prod_ff     <= prod_in;
      op_ff       <= op_in;
      val_ff      <= val_in;
      rej_ff      <= rej_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/rfpq_checker.sv -----
// Port-level checker for the range frequency-power query block, bound to its top level.
// Depends on rfpq_pkg and the assertion macros in assert_macros.svh.
`include "assert_macros.svh"

module rfpq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input rfpq_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rfpq_pkg::rsp_type rsp_data
);
   import rfpq_pkg::*;

   logic req_take;
   logic rsp_held;
   logic rsp_reject;
   logic reject_take;

   assign req_take    = req_valid && !req_stall;
   assign rsp_held    = rsp_valid && rsp_stall;
   assign rsp_reject  = rsp_valid && rsp_data.status == STATUS_REJECT;
   assign reject_take = req_take && req_data.cmd == CMD_QUERY &&
                        req_data.query_left > req_data.query_right;

   // A rejected answer always carries a zero sum.
   `RFPQ_ASSERT_IMPLY(a_reject_zero, clock, reset, rsp_reject, rsp_data.answer == '0)

   // A stalled result beat holds.
   `RFPQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data))

   // Every accepted query keeps the input side closed in the following cycle.
   `RFPQ_ASSERT_NEXT(a_query_busy, clock, reset, req_take && req_data.cmd == CMD_QUERY, req_stall)

   // An inverted range is answered through ST_REPLY and the output register when the output was free.
   `RFPQ_ASSERT_IMPLY(a_reject_fast, clock, reset, reject_take && !rsp_valid, ##2 rsp_reject)

   // The memory clearing pass keeps inputs off right after reset.
   `RFPQ_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, req_stall)

endmodule

bind range_frequency_power_query rfpq_checker u_rfpq_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the range frequency-power query block.
// Depends on rfpq_pkg and range_frequency_power_query; an in-bench window model predicts
// each answer, and a scoreboard checks every response beat against it in arrival order.
module testbench;
   import rfpq_pkg::*;

   localparam int    DEPTH          = 1024;
   localparam int    VALUES         = 128;
   localparam int    TOTAL_BEATS    = 1650;
   localparam int    HOT_SPAN       = 64;
   localparam longint TIMEOUT_UNITS = 64'd600_000_000;

   // Tracks the element store and the sliding window, and keeps the answers still owed.
   class window_sum_tracker;
      bit [ELEM_W-1:0]  stored [DEPTH];
      int unsigned      value_tally [VALUES];
      int unsigned      win_lo;
      int unsigned      win_hi;
      longint unsigned  run_sum;
      rsp_type          owed_answers [$];
      int               errors;

      function void take_in(int unsigned pos);
         int unsigned v;
         int unsigned c;
         v = 32'(stored[pos]);
         c = value_tally[v];
         run_sum += 64'((2 * c + 1) * v);
         value_tally[v] = c + 1;
      endfunction

      function void drop_out(int unsigned pos);
         int unsigned v;
         int unsigned c;
         v = 32'(stored[pos]);
         c = value_tally[v];
         if (c == 0) return;
         run_sum -= 64'((2 * c - 1) * v);
         value_tally[v] = c - 1;
      endfunction

      // With a 10-bit index and a 7-bit value, neither the write saturation nor the
      // query saturation can trigger at this configuration.
      function void note_beat(req_type beat);
         rsp_type     want;
         int unsigned lo;
         int unsigned hi_ex;
         if (beat.cmd == CMD_WRITE) begin
            stored[beat.element_index] = beat.element_value;
            foreach (value_tally[i]) value_tally[i] = 0;
            win_lo  = 0;
            win_hi  = 0;
            run_sum = 0;
            return;
         end
         if (beat.query_left > beat.query_right) begin
            want.answer = '0;
            want.status = STATUS_REJECT;
            owed_answers.push_back(want);
            return;
         end
         lo    = 32'(beat.query_left);
         hi_ex = 32'(beat.query_right) + 1;
         // An empty window restarts at the left edge of the query.
         if (win_lo == win_hi) begin
            win_lo = lo;
            win_hi = lo;
         end
         while (win_lo > lo) begin
            win_lo--;
            take_in(win_lo);
         end
         while (win_hi < hi_ex) begin
            take_in(win_hi);
            win_hi++;
         end
         while (win_hi > hi_ex) begin
            win_hi--;
            drop_out(win_hi);
         end
         while (win_lo < lo) begin
            drop_out(win_lo);
            win_lo++;
         end
         want.answer = run_sum[ANSWER_W-1:0];
         want.status = STATUS_OK;
         owed_answers.push_back(want);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (owed_answers.size() == 0) begin
            $display("%0t: answer beat with none owed: answer %0d status %0b",
                     $time, got.answer, got.status);
            errors++;
            return;
         end
         want = owed_answers.pop_front();
         if (got.answer !== want.answer) begin
            $display("%0t: answer expected %0d actual %0d", $time, want.answer, got.answer);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   window_sum_tracker tracker = new;
   int  beats_sent      = 0;
   int  receiver_hold   = 0;
   bit  steady_sender   = 1'b0;
   bit  steady_receiver = 1'b0;

   range_frequency_power_query uut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data
   );

   always #6 clock = ~clock;

   function automatic req_type make_write(int idx, int val);
      req_type beat;
      beat.cmd           = CMD_WRITE;
      beat.element_index = INDEX_W'(idx);
      beat.element_value = ELEM_W'(val);
      beat.query_left    = INDEX_W'($urandom_range(DEPTH - 1));
      beat.query_right   = INDEX_W'($urandom_range(DEPTH - 1));
      return beat;
   endfunction

   function automatic req_type make_query(int lo, int hi);
      req_type beat;
      beat.cmd           = CMD_QUERY;
      beat.element_index = INDEX_W'($urandom_range(DEPTH - 1));
      beat.element_value = ELEM_W'($urandom_range(VALUES - 1));
      beat.query_left    = INDEX_W'(lo);
      beat.query_right   = INDEX_W'(hi);
      return beat;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input req_type beat);
      int gap;
      gap = 0;
      if (!steady_sender && $urandom_range(99) < 19) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= beat;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.note_beat(beat);
      beats_sent++;
      @(negedge clock);
   endtask

   // Response side: random stalls, quiet stretches and one long hold-off.
   initial begin
      forever begin
         @(negedge clock);
         if (receiver_hold > 0) begin
            rsp_stall <= 1'b1;
            receiver_hold = receiver_hold - 1;
         end else if (steady_receiver) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 19);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.check_answer(rsp_data);
   end

   initial begin
      req_type beat;
      int      cur_lo;
      int      cur_hi;
      int      lo;
      int      hi;
      int      pick;
      int      val;
      int      idx;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty array, extreme positions and values, rejections.
      send_beat(make_query(0, 0));
      send_beat(make_query(0, DEPTH - 1));
      send_beat(make_write(0, VALUES - 1));
      send_beat(make_write(DEPTH - 1, VALUES - 1));
      send_beat(make_write(1, VALUES - 1));
      send_beat(make_write(2, 0));
      send_beat(make_write(3, 1));
      send_beat(make_write(4, VALUES - 1));
      send_beat(make_query(0, DEPTH - 1));
      send_beat(make_query(DEPTH - 1, DEPTH - 1));
      send_beat(make_query(0, 0));
      send_beat(make_query(DEPTH - 1, 0));
      send_beat(make_query(1, 0));
      send_beat(make_query(512, 511));
      send_beat(make_query(0, 4));
      send_beat(make_query(2, 2));
      beat = '{cmd: CMD_WRITE, element_index: 10'd5, element_value: 7'd127,
               query_left: '1, query_right: '1};
      send_beat(beat);
      beat = '{cmd: CMD_QUERY, element_index: '1, element_value: '1,
               query_left: 10'd0, query_right: 10'd5};
      send_beat(beat);
      send_beat(make_query(5, 5));
      send_beat(make_query(0, DEPTH - 1));

      // Random part: mostly small window moves near a hot region so that values repeat,
      // with writes, rejections and a few wide ranges mixed in.
      cur_lo = 0;
      cur_hi = 8;
      while (beats_sent < TOTAL_BEATS) begin
         steady_sender   = (beats_sent >= 700 && beats_sent < 900);
         steady_receiver = steady_sender;
         if (beats_sent == 400) receiver_hold = 900;
         if (beats_sent == 1100) begin
            req_valid <= 1'b0;
            while (tracker.owed_answers.size() != 0) @(posedge clock);
            @(negedge clock);
         end

         pick = $urandom_range(99);
         if (pick < 25) begin
            idx = ($urandom_range(9) < 7) ? $urandom_range(HOT_SPAN - 1)
                                          : $urandom_range(DEPTH - 1);
            case ($urandom_range(9))
               0, 1, 2, 3: val = ($urandom_range(2) == 0) ? 3 :
                                 ($urandom_range(1) == 0) ? 64 : VALUES - 1;
               4:          val = 0;
               default:    val = $urandom_range(VALUES - 1);
            endcase
            send_beat(make_write(idx, val));
            // A write empties the window, so keep the next range short.
            cur_lo = $urandom_range(HOT_SPAN - 1);
            cur_hi = cur_lo + $urandom_range(40);
         end else if (pick < 30) begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(lo - 1);
            send_beat(make_query(lo, hi));
         end else if (pick < 35) begin
            lo = $urandom_range(DEPTH - 1);
            hi = $urandom_range(DEPTH - 1);
            if (lo > hi) begin
               cur_lo = hi;
               cur_hi = lo;
            end else begin
               cur_lo = lo;
               cur_hi = hi;
            end
            if ($urandom_range(3) == 0) begin
               cur_lo = 0;
               cur_hi = DEPTH - 1;
            end
            send_beat(make_query(cur_lo, cur_hi));
         end else begin
            lo = cur_lo + int'($urandom_range(24)) - 12;
            hi = cur_hi + int'($urandom_range(24)) - 12;
            if (lo < 0) lo = 0;
            if (lo > DEPTH - 1) lo = DEPTH - 1;
            if (hi < 0) hi = 0;
            if (hi > DEPTH - 1) hi = DEPTH - 1;
            cur_lo = (lo > hi) ? hi : lo;
            cur_hi = (lo > hi) ? lo : hi;
            send_beat(make_query(cur_lo, cur_hi));
         end
      end
      req_valid <= 1'b0;
      steady_sender   = 1'b0;
      steady_receiver = 1'b0;

      while (tracker.owed_answers.size() != 0) @(posedge clock);
      // A trailing write may keep the block busy clearing counts without owing an answer.
      repeat (300) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("range_frequency_power_query: match");
      end else begin
         $display("range_frequency_power_query: mismatch");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("%0t: timeout with %0d answers owed", $time, tracker.owed_answers.size());
      $display("range_frequency_power_query: mismatch");
      $finish;
   end

endmodule
